// File: hw/rtl/srtm_pkg.sv
// shared constants and codes for the secure region table manager
package srtm_pkg;

  localparam int DEFAULT_REGION_SLOTS = 16;

  localparam int ADDR_W     = 64;
  localparam int MB_SHIFT   = 20;
  localparam int MB_W       = ADDR_W - MB_SHIFT;
  localparam int IDX_W      = 4;
  localparam int ACT_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int MASK_W     = 16;
  localparam int COUNT_W    = 5;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 120;

  localparam logic [ADDR_W-1:0] MB_MASK   = 64'h0000_0000_000F_FFFF;
  localparam logic [ADDR_W-1:0] TOP_LIMIT = 64'hFFFF_FFFF_FFF0_0000;

  // request actions
  localparam logic [ACT_W-1:0] ACT_RESERVE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOCATE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FREE     = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOPERM   = 3'd6;

endpackage

// File: hw/rtl/secure_region_table_manager_unit.sv
// secure region table manager: sequencer, shared adder and comparators, slot table
// steps to out_tvalid on success: free is decode, free, finish; reserve is decode, sum,
//   round, reserve, finish; allocate is decode, sum, round, scan (one slot per
//   cycle), alloc, finish; one request at a time, in_tready is high only while
//   the sequencer idles, so no new request is taken before the result is loaded
// reset: synchronous, active low; slot 0 in use (static, range zero), count one,
//   all enables clear, no result pending
module secure_region_table_manager_unit
  import srtm_pkg::*;
#(
  parameter int REGION_SLOTS = DEFAULT_REGION_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata, low bit up: region_index[3:0], start_address[63:0], region_size[63:0], pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: action[1:0]
  input  logic [ACT_W-1:0]      in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata, low bit up: status[2:0], granted_region[3:0], range_start_mb[43:0],
  //   range_last_mb[43:0], enable_mask[15:0], used_count[4:0], pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int SLOT_W = $clog2(REGION_SLOTS);
  localparam int CNT_W  = $clog2(REGION_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(REGION_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SUM,
    S_ROUND,
    S_RESERVE,
    S_SCAN,
    S_ALLOC,
    S_FREE,
    S_FINISH
  } state_t;

  state_t state_r;

  // latched request
  logic [ACT_W-1:0]    act_r;
  logic [IDX_W-1:0]    idx_r;
  logic [ADDR_W-1:0]   st_r;
  logic [ADDR_W-1:0]   sz_r;

  // working registers
  logic [ADDR_W:0]     sum_r;      // start + size with carry
  logic [MB_W-1:0]     smb_r;      // first MiB
  logic [MB_W-1:0]     emb_r;      // MiB just past the range
  logic                have_range_r;
  logic [STATUS_W-1:0] status_r;
  logic [IDX_W-1:0]    granted_r;
  logic [SLOT_W-1:0]   scan_r;
  logic [SLOT_W-1:0]   free_r;
  logic                found_r;

  // slot table
  logic [REGION_SLOTS-1:0] used_r;
  logic [REGION_SLOTS-1:0] dyn_r;
  logic [REGION_SLOTS-1:0] enables_r;
  logic [MB_W-1:0]         start_r [REGION_SLOTS];
  logic [MB_W-1:0]         end_r   [REGION_SLOTS];
  logic [CNT_W-1:0]        count_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // shared datapath signals
  logic [SLOT_W-1:0] idx_slot;
  logic              idx_ok;
  logic [SLOT_W-1:0] rd_slot;
  logic [MB_W-1:0]   rd_start;
  logic [MB_W-1:0]   rd_end;
  logic [ADDR_W-1:0] add_a;
  logic [ADDR_W-1:0] add_b;
  logic [ADDR_W:0]   add_res;
  logic [MB_W-1:0]   cmp0_b;
  logic [MB_W-1:0]   cmp1_a;
  logic              cmp0_lt;
  logic              cmp1_lt;
  logic              scan_hit;

  assign idx_slot = SLOT_W'(idx_r);
  assign idx_ok   = (32'(idx_r) < REGION_SLOTS);

  // single table read port: scan pointer while scanning, request index otherwise
  assign rd_slot  = (state_r == S_SCAN) ? scan_r : idx_slot;
  assign rd_start = start_r[rd_slot];
  assign rd_end   = end_r[rd_slot];

  // shared 64-bit adder: end address, then round up to the next MiB
  assign add_a   = (state_r == S_SUM) ? st_r : sum_r[ADDR_W-1:0];
  assign add_b   = (state_r == S_SUM) ? sz_r : MB_MASK;
  assign add_res = {1'b0, add_a} + {1'b0, add_b};

  // shared comparator pair: overlap test while scanning, merge test on reserve
  assign cmp0_b  = (state_r == S_SCAN) ? rd_end : rd_start;
  assign cmp1_a  = (state_r == S_SCAN) ? rd_start : rd_end;
  assign cmp0_lt = (smb_r < cmp0_b);
  assign cmp1_lt = (cmp1_a < emb_r);
  assign scan_hit = used_r[scan_r] && cmp0_lt && cmp1_lt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= REGION_SLOTS'(1);
      dyn_r       <= '0;
      enables_r   <= '0;
      count_r     <= CNT_W'(1);
      for (int i = 0; i < REGION_SLOTS; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
    end else begin
      // result beat taken; in the finish state the new beat is loaded instead
      if (out_valid_r && out_tready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            act_r   <= in_tuser;
            idx_r   <= in_tdata[IDX_W-1:0];
            st_r    <= in_tdata[IDX_W +: ADDR_W];
            sz_r    <= in_tdata[IDX_W+ADDR_W +: ADDR_W];
            state_r <= S_DECODE;
          end
        end

        S_DECODE: begin
          have_range_r <= 1'b0;
          status_r     <= ST_INVALID;
          granted_r    <= ((act_r == ACT_RESERVE) || (act_r == ACT_FREE)) ? idx_r : '0;
          if (act_r == ACT_ALLOCATE) begin
            state_r <= S_SUM;
          end else if (act_r == ACT_RESERVE) begin
            state_r <= idx_ok ? S_SUM : S_FINISH;
          end else if (act_r == ACT_FREE) begin
            state_r <= idx_ok ? S_FREE : S_FINISH;
          end else begin
            // unknown action
            state_r <= S_FINISH;
          end
        end

        S_SUM: begin
          sum_r   <= add_res;
          state_r <= S_ROUND;
        end

        S_ROUND: begin
          if (sz_r == '0) begin
            status_r <= ST_INVALID;
            state_r  <= S_FINISH;
          end else if (sum_r[ADDR_W] || (sum_r[ADDR_W-1:0] > TOP_LIMIT)) begin
            // wrapped past the top of space or above the last whole MiB
            status_r <= ST_RANGE;
            state_r  <= S_FINISH;
          end else begin
            smb_r        <= st_r[ADDR_W-1:MB_SHIFT];
            emb_r        <= add_res[ADDR_W-1:MB_SHIFT];
            have_range_r <= 1'b1;
            scan_r       <= '0;
            found_r      <= 1'b0;
            free_r       <= '0;
            state_r      <= (act_r == ACT_RESERVE) ? S_RESERVE : S_SCAN;
          end
        end

        S_RESERVE: begin
          // enable goes on even when the kind check fails
          enables_r[idx_slot] <= 1'b1;
          if (used_r[idx_slot]) begin
            if (dyn_r[idx_slot]) begin
              status_r <= ST_BUSY;
            end else begin
              if ((rd_start == '0) || cmp0_lt) begin
                start_r[idx_slot] <= smb_r;
              end
              if (cmp1_lt) begin
                end_r[idx_slot] <= emb_r;
              end
              status_r <= ST_OK;
            end
          end else begin
            used_r[idx_slot]  <= 1'b1;
            dyn_r[idx_slot]   <= 1'b0;
            start_r[idx_slot] <= smb_r;
            end_r[idx_slot]   <= emb_r;
            count_r           <= count_r + CNT_W'(1);
            status_r          <= ST_OK;
          end
          state_r <= S_FINISH;
        end

        S_SCAN: begin
          if (scan_hit) begin
            status_r <= ST_BUSY;
            state_r  <= S_FINISH;
          end else begin
            // remember the lowest free slot
            if (!used_r[scan_r] && !found_r) begin
              free_r  <= scan_r;
              found_r <= 1'b1;
            end
            if (scan_r == LAST_SLOT) begin
              state_r <= S_ALLOC;
            end else begin
              scan_r <= scan_r + SLOT_W'(1);
            end
          end
        end

        S_ALLOC: begin
          if (!found_r) begin
            status_r <= ST_NOSPACE;
          end else begin
            enables_r[free_r] <= 1'b1;
            used_r[free_r]    <= 1'b1;
            dyn_r[free_r]     <= 1'b1;
            start_r[free_r]   <= smb_r;
            end_r[free_r]     <= emb_r;
            count_r           <= count_r + CNT_W'(1);
            granted_r         <= IDX_W'(free_r);
            status_r          <= ST_OK;
          end
          state_r <= S_FINISH;
        end

        S_FREE: begin
          if (!used_r[idx_slot]) begin
            status_r <= ST_NOTFOUND;
          end else if (!dyn_r[idx_slot]) begin
            // static slots stay put
            status_r <= ST_NOPERM;
          end else begin
            enables_r[idx_slot] <= 1'b0;
            used_r[idx_slot]    <= 1'b0;
            dyn_r[idx_slot]     <= 1'b0;
            start_r[idx_slot]   <= '0;
            end_r[idx_slot]     <= '0;
            if (count_r != '0) begin
              count_r <= count_r - CNT_W'(1);
            end
            status_r <= ST_OK;
          end
          state_r <= S_FINISH;
        end

        S_FINISH: begin
          // wait for the output register to free up
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {
              (OUT_DATA_W - (STATUS_W + IDX_W + 2 * MB_W + MASK_W + COUNT_W))'(0),
              COUNT_W'(count_r),
              MASK_W'(enables_r),
              have_range_r ? (emb_r - MB_W'(1)) : MB_W'(0),
              have_range_r ? smb_r : MB_W'(0),
              granted_r,
              status_r
            };
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
